// File: src/bhq_pkg.sv
package bhq_pkg;

  localparam int unsigned BHQ_CAPACITY = 1024;
  localparam int unsigned BHQ_KEY_BITS = 32;
  localparam int unsigned BHQ_TAG_BITS = 16;

  localparam int unsigned FUNC_BITS   = 1;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_PUSH = 1'b0;
  localparam logic [FUNC_BITS-1:0] FUNC_POP  = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;          // latch the incoming transfer
    logic push_init;     // pos <= count, count++
    logic pop_init;      // read root and last, count--
    logic pop_load;      // capture root as result, last as moving entry
    logic rd_up;         // read parent of pos
    logic rd_kids;       // read both children of pos
    logic wr_final;      // write moving entry at pos
    logic wr_move_up;    // parent moves down into pos, pos <= parent
    logic wr_move_down;  // chosen child moves up into pos, pos <= child
    logic out_load;      // copy result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic refused;
    logic pos_zero;
    logic parent_le;
    logic child_out;
    logic stop_down;
  } sts_t;

endpackage

// File: src/bhq_dp.sv
module bhq_dp import bhq_pkg::*; #(
  parameter int unsigned CAPACITY = BHQ_CAPACITY,
  parameter int unsigned KEY_BITS = BHQ_KEY_BITS,
  parameter int unsigned TAG_BITS = BHQ_TAG_BITS,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [FUNC_BITS-1:0]   func_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [TAG_BITS-1:0]    tag_i,
  output logic [STATUS_BITS-1:0] out_status_o,
  output logic [KEY_BITS-1:0]    out_key_o,
  output logic [TAG_BITS-1:0]    out_tag_o,
  output logic [CW-1:0]          out_fill_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = AW + 2;
  localparam int unsigned EW = KEY_BITS + TAG_BITS;

  // entry layout: {tag, key}
  logic [EW-1:0] mem [CAPACITY];

  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [FUNC_BITS-1:0]   func_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic [STATUS_BITS-1:0] res_status_q;
  logic [KEY_BITS-1:0]    res_key_q;
  logic [TAG_BITS-1:0]    res_tag_q;
  logic [EW-1:0]          rd_a_q, rd_b_q;

  logic [STATUS_BITS-1:0] out_status_q;
  logic [KEY_BITS-1:0]    out_key_q;
  logic [TAG_BITS-1:0]    out_tag_q;
  logic [CW-1:0]          out_fill_q;

  logic [AW-1:0]  pos_dec, up_idx;
  logic [CW-1:0]  cnt_dec;
  logic [XW-1:0]  child_x, right_x, cnt_x;
  logic           right_ok, pick_right;
  logic [EW-1:0]  chosen;
  logic [AW-1:0]  chosen_idx;
  logic [KEY_BITS-1:0] a_key, b_key;

  logic           rd_en, wr_en;
  logic [AW-1:0]  addr_a, addr_b, wr_addr;
  logic [EW-1:0]  wr_data;
  logic           full, empty;
  logic [STATUS_BITS-1:0] load_status;

  assign full  = (cnt_q == CW'(CAPACITY));
  assign empty = (cnt_q == '0);

  assign pos_dec = pos_q - AW'(1);
  assign up_idx  = pos_dec >> 1;
  assign cnt_dec = cnt_q - CW'(1);

  assign child_x = XW'({pos_q, 1'b1});
  assign right_x = child_x + XW'(1);
  assign cnt_x   = XW'(cnt_q);

  assign a_key = rd_a_q[KEY_BITS-1:0];
  assign b_key = rd_b_q[KEY_BITS-1:0];

  // equal children: the right one wins
  assign right_ok   = (right_x < cnt_x);
  assign pick_right = right_ok && (b_key <= a_key);
  assign chosen     = pick_right ? rd_b_q : rd_a_q;
  assign chosen_idx = pick_right ? right_x[AW-1:0] : child_x[AW-1:0];

  assign sts_o.is_pop    = (func_q == FUNC_POP);
  assign sts_o.refused   = (res_status_q != STAT_OK);
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.parent_le = (a_key <= key_q);
  assign sts_o.child_out = (child_x >= cnt_x);
  assign sts_o.stop_down = (key_q <= chosen[KEY_BITS-1:0]);

  always_comb begin
    load_status = STAT_OK;
    if (func_i == FUNC_POP) begin
      if (empty) load_status = STAT_EMPTY;
    end else begin
      if (full) load_status = STAT_FULL;
    end
  end

  // memory ports
  always_comb begin
    rd_en  = cmd_i.rd_up | cmd_i.rd_kids | cmd_i.pop_init;
    addr_a = '0;
    addr_b = cnt_dec[AW-1:0];
    if (cmd_i.rd_up) begin
      addr_a = up_idx;
    end else if (cmd_i.rd_kids) begin
      addr_a = child_x[AW-1:0];
      addr_b = right_x[AW-1:0];
    end
    wr_en   = cmd_i.wr_final | cmd_i.wr_move_up | cmd_i.wr_move_down;
    wr_addr = pos_q;
    if (cmd_i.wr_move_up) begin
      wr_data = rd_a_q;
    end else if (cmd_i.wr_move_down) begin
      wr_data = chosen;
    end else begin
      wr_data = {tag_q, key_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (cmd_i.push_init) begin
      pos_d = cnt_q[AW-1:0];
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.pop_init) begin
      cnt_d = cnt_dec;
    end
    if (cmd_i.pop_load) begin
      pos_d = '0;
    end
    if (cmd_i.wr_move_up) begin
      pos_d = up_idx;
    end
    if (cmd_i.wr_move_down) begin
      pos_d = chosen_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= func_i;
      key_q        <= key_i;
      tag_q        <= tag_i;
      res_status_q <= load_status;
      res_key_q    <= '0;
      res_tag_q    <= '0;
    end
    if (cmd_i.pop_load) begin
      res_key_q <= a_key;
      res_tag_q <= rd_a_q[KEY_BITS +: TAG_BITS];
      key_q     <= b_key;
      tag_q     <= rd_b_q[KEY_BITS +: TAG_BITS];
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_tag_q    <= res_tag_q;
      out_fill_q   <= cnt_q;
    end
  end

  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;
  assign out_tag_o    = out_tag_q;
  assign out_fill_o   = out_fill_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_push_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_init |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("push did not grow the count by one");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_init |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("pop did not shrink the count by one");

  a_fill_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (out_fill_q == $past(cnt_q)))
    else $error("reported fill differs from count");
`endif

endmodule

// File: src/bhq_ctrl.sv
module bhq_ctrl import bhq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_PU_ISSUE,
    S_PU_CMP,
    S_PO_LOAD,
    S_PO_ISSUE,
    S_PO_CMP,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.refused) begin
          state_d = S_FIN;
        end else if (sts_i.is_pop) begin
          cmd_o.pop_init = 1'b1;
          state_d        = S_PO_LOAD;
        end else begin
          cmd_o.push_init = 1'b1;
          state_d         = S_PU_ISSUE;
        end
      end
      S_PU_ISSUE: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_final = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.rd_up = 1'b1;
          state_d     = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        if (sts_i.parent_le) begin
          cmd_o.wr_final = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.wr_move_up = 1'b1;
          state_d          = S_PU_ISSUE;
        end
      end
      S_PO_LOAD: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_PO_ISSUE;
      end
      S_PO_ISSUE: begin
        if (sts_i.child_out) begin
          cmd_o.wr_final = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.rd_kids = 1'b1;
          state_d       = S_PO_CMP;
        end
      end
      S_PO_CMP: begin
        if (sts_i.stop_down) begin
          cmd_o.wr_final = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.wr_move_down = 1'b1;
          state_d            = S_PO_ISSUE;
        end
      end
      S_FIN: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECIDE))
    else $error("accepted transfer not decoded");

  a_valid_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result dropped without transfer");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN))
    else $error("result overwritten while output busy");
`endif

endmodule

// File: src/binary_min_heap_queue.sv
// A push sifts up by parent compares and a pop sifts down by child compares
// until the entry settles; the heap holds up to 1024 entries by default.
// One operation at a time: the next transfer is taken in the cycle after
// the result is loaded into the output register.
// A new transfer is taken while a result waits; its result then waits in turn.
// Reset (async, active low) empties the heap; storage is not cleared.
module binary_min_heap_queue import bhq_pkg::*; #(
  parameter int unsigned CAPACITY = BHQ_CAPACITY,
  parameter int unsigned KEY_BITS = BHQ_KEY_BITS,
  parameter int unsigned TAG_BITS = BHQ_TAG_BITS,
  localparam int unsigned CW    = $clog2(CAPACITY + 1),
  localparam int unsigned IN_W  = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((KEY_BITS + TAG_BITS + CW + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_W-1:0]        s_axis_tdata_i,   // item_key, item_tag
  input  logic [FUNC_BITS-1:0]   s_axis_tuser_i,   // func
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_W-1:0]       m_axis_tdata_o,   // min_key, min_tag, fill_count
  output logic [STATUS_BITS-1:0] m_axis_tuser_o    // status
);

  cmd_t cmd;
  sts_t sts;

  logic [KEY_BITS-1:0] out_key;
  logic [TAG_BITS-1:0] out_tag;
  logic [CW-1:0]       out_fill;

  bhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bhq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (s_axis_tuser_i),
    .key_i        (s_axis_tdata_i[KEY_BITS-1:0]),
    .tag_i        (s_axis_tdata_i[KEY_BITS +: TAG_BITS]),
    .out_status_o (m_axis_tuser_o),
    .out_key_o    (out_key),
    .out_tag_o    (out_tag),
    .out_fill_o   (out_fill)
  );

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[KEY_BITS-1:0]                = out_key;
    m_axis_tdata_o[KEY_BITS +: TAG_BITS]        = out_tag;
    m_axis_tdata_o[KEY_BITS + TAG_BITS +: CW]   = out_fill;
  end

endmodule

// File: dv/bhq_result_check.sv
`timescale 1ns / 1ps

module bhq_result_check import bhq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [47:0]            s_tdata_i,   // item_key, item_tag
  input  logic [FUNC_BITS-1:0]   s_tuser_i,   // func
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [63:0]            m_tdata_i,   // min_key, min_tag, fill_count
  input  logic [STATUS_BITS-1:0] m_tuser_i,   // status
  output int unsigned            fail_cnt_o,
  output int unsigned            pending_o
);

  localparam int unsigned CAP = BHQ_CAPACITY;

  typedef struct packed {
    status_e                 status;
    logic [BHQ_KEY_BITS-1:0] min_key;
    logic [BHQ_TAG_BITS-1:0] min_tag;
    logic [10:0]             fill;
  } heap_result_t;

  // shadow heap
  logic [BHQ_KEY_BITS-1:0] heap_key [CAP];
  logic [BHQ_TAG_BITS-1:0] heap_tag [CAP];
  int unsigned             heap_count;

  heap_result_t queued_results [$];
  int unsigned  fails;

  function automatic heap_result_t heap_apply(logic [FUNC_BITS-1:0] func,
                                              logic [BHQ_KEY_BITS-1:0] k,
                                              logic [BHQ_TAG_BITS-1:0] t);
    heap_result_t            r;
    int unsigned             pos;
    int unsigned             up;
    int unsigned             child;
    logic [BHQ_KEY_BITS-1:0] mk;
    logic [BHQ_TAG_BITS-1:0] mt;
    logic                    stop;
    r.status  = STAT_OK;
    r.min_key = '0;
    r.min_tag = '0;
    if (func == FUNC_PUSH) begin
      if (heap_count >= CAP) begin
        r.status = STAT_FULL;
      end else begin
        pos = heap_count;
        heap_count++;
        stop = 1'b0;
        while (pos != 0 && !stop) begin
          up = (pos - 1) >> 1;
          if (heap_key[up] <= k) begin
            stop = 1'b1;
          end else begin
            heap_key[pos] = heap_key[up];
            heap_tag[pos] = heap_tag[up];
            pos = up;
          end
        end
        heap_key[pos] = k;
        heap_tag[pos] = t;
      end
    end else begin
      if (heap_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.min_key = heap_key[0];
        r.min_tag = heap_tag[0];
        heap_count--;
        mk = heap_key[heap_count];
        mt = heap_tag[heap_count];
        pos = 0;
        stop = 1'b0;
        while (!stop) begin
          child = 2 * pos + 1;
          if (child >= heap_count) begin
            stop = 1'b1;
          end else begin
            // ties go to the right child
            if (child + 1 < heap_count && heap_key[child+1] <= heap_key[child])
              child = child + 1;
            if (mk <= heap_key[child]) begin
              stop = 1'b1;
            end else begin
              heap_key[pos] = heap_key[child];
              heap_tag[pos] = heap_tag[child];
              pos = child;
            end
          end
        end
        heap_key[pos] = mk;
        heap_tag[pos] = mt;
      end
    end
    r.fill = heap_count[10:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t exp_r;
    heap_result_t act_r;
    if (!rst_ni) begin
      heap_count = 0;
      queued_results.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        act_r.status  = status_e'(m_tuser_i);
        act_r.min_key = m_tdata_i[31:0];
        act_r.min_tag = m_tdata_i[47:32];
        act_r.fill    = m_tdata_i[58:48];
        if (queued_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with nothing expected: st=%0d key=%h tag=%h fill=%0d",
                     $realtime, act_r.status, act_r.min_key, act_r.min_tag, act_r.fill);
        end else begin
          exp_r = queued_results.pop_front();
          if (act_r.status !== exp_r.status || act_r.min_key !== exp_r.min_key ||
              act_r.min_tag !== exp_r.min_tag || act_r.fill !== exp_r.fill) begin
            fails++;
            if (fails <= 10)
              $display("%0t: exp st=%0d key=%h tag=%h fill=%0d, got st=%0d key=%h tag=%h fill=%0d",
                       $realtime, exp_r.status, exp_r.min_key, exp_r.min_tag, exp_r.fill,
                       act_r.status, act_r.min_key, act_r.min_tag, act_r.fill);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        queued_results.push_back(heap_apply(s_tuser_i, s_tdata_i[31:0], s_tdata_i[47:32]));
      fail_cnt_o <= fails;
      pending_o  <= queued_results.size();
    end
  end

endmodule

// File: dv/tb_binary_min_heap_queue.sv
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
  import bhq_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [47:0]            s_tdata = '0;     // item_key, item_tag
  logic [FUNC_BITS-1:0]   s_tuser = FUNC_PUSH;  // func
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [63:0]            m_tdata;          // min_key, min_tag, fill_count
  logic [STATUS_BITS-1:0] m_tuser;          // status

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  binary_min_heap_queue u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  bhq_result_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // receiver stall pattern: free-running, stalled, random and sparse stretches
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(2, 30) : $urandom_range(8, 64);
    end
    rx_left--;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("binary_min_heap_queue: mismatch");
        $finish;
      end
    end
  end

  task automatic send_item(logic [FUNC_BITS-1:0] func, logic [31:0] k, logic [15:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {t, k};
    s_tuser  <= func;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
  endtask

  // stop sending and hold off until every result has been taken
  task automatic drain;
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 15));   // dense keys for ties
      1: return 32'h0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int unsigned n, int unsigned push_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) <= push_pct)
        send_item(FUNC_PUSH, pick_key(), 16'($urandom_range(0, 65535)));
      else
        send_item(FUNC_POP, 32'($urandom), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pop, key extremes, equal keys on both sift paths
    send_item(FUNC_POP, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(FUNC_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(FUNC_PUSH, 32'h0, 16'h0);
    send_item(FUNC_PUSH, 32'd5, 16'h1111);
    send_item(FUNC_PUSH, 32'd5, 16'h2222);
    send_item(FUNC_PUSH, 32'd5, 16'h3333);
    send_item(FUNC_PUSH, 32'h8000_0000, 16'h8000);
    send_item(FUNC_PUSH, 32'd5, 16'h4444);
    repeat (7) send_item(FUNC_POP, 32'h0, 16'h0);
    send_item(FUNC_POP, 32'h0, 16'h0);
    send_item(FUNC_PUSH, 32'd7, 16'hA5A5);
    send_item(FUNC_PUSH, 32'd7, 16'h5A5A);
    send_item(FUNC_PUSH, 32'd7, 16'h0F0F);
    repeat (4) send_item(FUNC_POP, 32'h0, 16'h0);
    drain();

    // random: churn near empty, fill to capacity and beyond, then mostly pops
    run_random(120, 50);
    drain();
    run_random(1100, 98);
    drain();
    run_random(380, 15);
    drain();

    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0)
      $display("binary_min_heap_queue: match");
    else
      $display("binary_min_heap_queue: mismatch");
    $finish;
  end

endmodule
